>>> hdl/tts_pkg.sv
// Package for the timed task scheduler table.
// Holds operation and result codes, field widths and the decoded command type.
// No dependencies.
package tts_pkg;

  localparam int ID_W    = 16;
  localparam int DELAY_W = 16;
  localparam int TIME_W  = 32;
  localparam int SLEEP_W = 16;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [OP_W-1:0] OP_SCHEDULE   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_IVAL   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNSCHEDULE = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK       = 2'd3;

  localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DUE       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd4;

  localparam logic [ID_W-1:0]    FIRST_ID        = 16'd1;
  localparam logic [ID_W-1:0]    LAST_ID         = 16'hFFFF;
  localparam logic [SLEEP_W-1:0] MAX_SLEEP_RESET = 16'd10;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    target_id;
    logic [DELAY_W-1:0] delay_seconds;
    logic               repeat_req;
  } cmd_t;

endpackage

>>> hdl/tts_front.sv
// Front end of the timed task scheduler table: unpacks input transactions
// into commands and holds them in a two-entry queue for the engine.
// Depends on tts_pkg.
module tts_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tts_pkg::IN_DATA_W-1:0]  in_tdata,   // target_id, delay_seconds, repeat_req
  input  logic [tts_pkg::OP_W-1:0]       in_tuser,   // operation
  output tts_pkg::cmd_t                  cmd,
  output logic                           cmd_valid,
  input  logic                           cmd_pop
);
  import tts_pkg::*;

  cmd_t        q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  logic        pop;
  cmd_t        in_cmd;

  assign in_cmd.op            = in_tuser;
  assign in_cmd.target_id     = in_tdata[15:0];
  assign in_cmd.delay_seconds = in_tdata[31:16];
  assign in_cmd.repeat_req    = in_tdata[32];

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

>>> hdl/tts_engine.sv
// Back end of the timed task scheduler table: task table, seconds counter,
// sequential search, tick scan and selection sort, and the result register.
// Depends on tts_pkg.
module tts_engine #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tts_pkg::cmd_t                   cmd,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  input  logic                            cfg_wr_en,
  input  logic [tts_pkg::SLEEP_W-1:0]     cfg_wr_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tts_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [tts_pkg::KIND_W-1:0]      out_tuser,
  output logic                            out_tlast
);
  import tts_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND    = 4'd1;
  localparam logic [3:0] S_TICK    = 4'd2;
  localparam logic [3:0] S_RS_INIT = 4'd3;
  localparam logic [3:0] S_RS_SCAN = 4'd4;
  localparam logic [3:0] S_RS_SWAP = 4'd5;
  localparam logic [3:0] S_RS_CLR  = 4'd6;
  localparam logic [3:0] S_EMIT    = 4'd7;

  logic [ID_W-1:0]    slot_id_r  [TABLE_DEPTH];
  logic [TIME_W-1:0]  slot_due_r [TABLE_DEPTH];
  logic [DELAY_W-1:0] slot_per_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] slot_val_r;

  logic [3:0]         state_r, state_nxt;
  logic [CW-1:0]      live_r, live_nxt;
  logic [ID_W-1:0]    next_id_r, next_id_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [SLEEP_W-1:0] max_sleep_r;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [CW-1:0]      kept_r, kept_nxt;
  logic [IW-1:0]      m_r, m_nxt;
  logic               m_ok_r, m_ok_nxt;
  logic [TIME_W-1:0]  mdue_r, mdue_nxt;
  logic [ID_W-1:0]    cur_id_r, cur_id_nxt;
  logic [TIME_W-1:0]  cur_due_r, cur_due_nxt;
  logic [DELAY_W-1:0] cur_per_r, cur_per_nxt;
  logic               cur_val_r, cur_val_nxt;
  logic               fired_r, fired_nxt;
  logic [SLEEP_W-1:0] sleep_r, sleep_nxt;
  logic [KIND_W-1:0]  fin_kind_r, fin_kind_nxt;
  logic [ID_W-1:0]    fin_id_r, fin_id_nxt;
  logic               fin_found_r, fin_found_nxt;
  cmd_t               cmd_r, cmd_nxt;

  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_found_r;
  logic [SLEEP_W-1:0] out_sleep_r;
  logic               out_last_r;

  logic [IW-1:0]      rd_idx;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  rd_due;
  logic [DELAY_W-1:0] rd_per;
  logic               rd_val;
  logic [TIME_W-1:0]  gap;

  logic               wa_en, wb_en, clr_tail;
  logic [IW-1:0]      wa_idx, wb_idx;
  logic [ID_W-1:0]    wa_id, wb_id;
  logic [TIME_W-1:0]  wa_due, wb_due;
  logic [DELAY_W-1:0] wa_per, wb_per;
  logic               wa_val, wb_val;

  logic               out_free;
  logic               push;
  logic [KIND_W-1:0]  push_kind;
  logic [ID_W-1:0]    push_id;
  logic               push_found;
  logic [SLEEP_W-1:0] push_sleep;
  logic               push_last;

  always_comb begin
    unique case (state_r)
      S_RS_SWAP: rd_idx = m_r;
      S_RS_SCAN: rd_idx = j_r[IW-1:0];
      default:   rd_idx = i_r[IW-1:0];
    endcase
  end

  assign rd_id    = slot_id_r[rd_idx];
  assign rd_due   = slot_due_r[rd_idx];
  assign rd_per   = slot_per_r[rd_idx];
  assign rd_val   = slot_val_r[rd_idx];
  assign gap      = rd_due - now_r;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    next_id_nxt   = next_id_r;
    now_nxt       = now_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    kept_nxt      = kept_r;
    m_nxt         = m_r;
    m_ok_nxt      = m_ok_r;
    mdue_nxt      = mdue_r;
    cur_id_nxt    = cur_id_r;
    cur_due_nxt   = cur_due_r;
    cur_per_nxt   = cur_per_r;
    cur_val_nxt   = cur_val_r;
    fired_nxt     = fired_r;
    sleep_nxt     = sleep_r;
    fin_kind_nxt  = fin_kind_r;
    fin_id_nxt    = fin_id_r;
    fin_found_nxt = fin_found_r;
    cmd_nxt       = cmd_r;
    cmd_pop       = 1'b0;
    wa_en = 1'b0; wa_idx = rd_idx; wa_id = rd_id; wa_due = rd_due; wa_per = rd_per;
    wa_val = rd_val;
    wb_en = 1'b0; wb_idx = m_r; wb_id = cur_id_r; wb_due = cur_due_r; wb_per = cur_per_r;
    wb_val = cur_val_r;
    clr_tail   = 1'b0;
    push       = 1'b0;
    push_kind  = fin_kind_r;
    push_id    = fin_id_r;
    push_found = fin_found_r;
    push_sleep = '0;
    push_last  = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop       = 1'b1;
          cmd_nxt       = cmd;
          i_nxt         = '0;
          kept_nxt      = '0;
          fin_id_nxt    = '0;
          fin_found_nxt = 1'b0;
          unique case (cmd.op)
            OP_SCHEDULE: begin
              if (live_r >= DEPTH_C) begin
                fin_kind_nxt = KIND_FULL;
                state_nxt    = S_EMIT;
              end else begin
                wa_en  = 1'b1;
                wa_idx = live_r[IW-1:0];
                wa_id  = next_id_r;
                wa_due = now_r + TIME_W'(cmd.delay_seconds);
                wa_per = cmd.repeat_req ? cmd.delay_seconds : '0;
                wa_val = 1'b1;
                live_nxt     = live_r + 1'b1;
                next_id_nxt  = (next_id_r == LAST_ID) ? FIRST_ID : next_id_r + 1'b1;
                fin_kind_nxt = KIND_SCHEDULED;
                fin_id_nxt   = next_id_r;
                state_nxt    = S_RS_INIT;
              end
            end
            OP_SET_IVAL, OP_UNSCHEDULE: begin
              fin_kind_nxt = KIND_ACK;
              state_nxt    = S_FIND;
            end
            default: begin
              now_nxt      = now_r + 1'b1;
              fired_nxt    = 1'b0;
              sleep_nxt    = max_sleep_r;
              fin_kind_nxt = KIND_TICK_DONE;
              state_nxt    = S_TICK;
            end
          endcase
        end
      end
      S_FIND: begin
        if (i_r >= live_r) begin
          state_nxt = S_RS_INIT;
          i_nxt     = '0;
        end else if (rd_val && rd_id == cmd_r.target_id) begin
          fin_found_nxt = 1'b1;
          wa_en         = 1'b1;
          if (cmd_r.op == OP_SET_IVAL) begin
            wa_due = now_r + TIME_W'(cmd_r.delay_seconds);
            wa_per = cmd_r.delay_seconds;
          end else begin
            wa_val = 1'b0;
          end
          state_nxt = S_RS_INIT;
          i_nxt     = '0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_TICK: begin
        if (i_r < live_r && rd_val) begin
          if (now_r >= rd_due) begin
            if (out_free) begin
              push       = 1'b1;
              push_kind  = KIND_DUE;
              push_id    = rd_id;
              push_found = 1'b0;
              push_last  = 1'b0;
              fired_nxt  = 1'b1;
              wa_en      = 1'b1;
              if (rd_per != '0) begin
                wa_due = now_r + TIME_W'(rd_per);
                if (sleep_r > rd_per) begin
                  sleep_nxt = rd_per;
                end
              end else begin
                wa_val = 1'b0;
              end
              i_nxt = i_r + 1'b1;
            end
          end else begin
            if (gap < TIME_W'(sleep_r)) begin
              sleep_nxt = gap[SLEEP_W-1:0];
            end
            i_nxt     = '0;
            state_nxt = fired_r ? S_RS_INIT : S_EMIT;
          end
        end else begin
          i_nxt     = '0;
          state_nxt = fired_r ? S_RS_INIT : S_EMIT;
        end
      end
      S_RS_INIT: begin
        if (i_r >= live_r) begin
          state_nxt = S_RS_CLR;
        end else begin
          cur_id_nxt  = rd_id;
          cur_due_nxt = rd_due;
          cur_per_nxt = rd_per;
          cur_val_nxt = rd_val;
          m_ok_nxt    = rd_val;
          m_nxt       = i_r[IW-1:0];
          mdue_nxt    = rd_due;
          j_nxt       = i_r + 1'b1;
          state_nxt   = S_RS_SCAN;
        end
      end
      S_RS_SCAN: begin
        if (j_r >= live_r) begin
          state_nxt = S_RS_SWAP;
        end else begin
          if (rd_val && (!m_ok_r || rd_due < mdue_r)) begin
            m_nxt    = j_r[IW-1:0];
            mdue_nxt = rd_due;
            m_ok_nxt = 1'b1;
          end
          j_nxt = j_r + 1'b1;
        end
      end
      S_RS_SWAP: begin
        if (m_ok_r) begin
          kept_nxt = kept_r + 1'b1;
          if (m_r != i_r[IW-1:0]) begin
            wa_en  = 1'b1;
            wa_idx = i_r[IW-1:0];
            wb_en  = 1'b1;
          end
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_RS_INIT;
      end
      S_RS_CLR: begin
        clr_tail  = 1'b1;
        live_nxt  = kept_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          push       = 1'b1;
          push_sleep = (fin_kind_r == KIND_TICK_DONE) ? sleep_r : '0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      next_id_r   <= FIRST_ID;
      now_r       <= '0;
      max_sleep_r <= MAX_SLEEP_RESET;
      fired_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      live_r    <= live_nxt;
      next_id_r <= next_id_nxt;
      now_r     <= now_nxt;
      fired_r   <= fired_nxt;
      if (cfg_wr_en) begin
        max_sleep_r <= cfg_wr_data;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    kept_r      <= kept_nxt;
    m_r         <= m_nxt;
    m_ok_r      <= m_ok_nxt;
    mdue_r      <= mdue_nxt;
    cur_id_r    <= cur_id_nxt;
    cur_due_r   <= cur_due_nxt;
    cur_per_r   <= cur_per_nxt;
    cur_val_r   <= cur_val_nxt;
    sleep_r     <= sleep_nxt;
    fin_kind_r  <= fin_kind_nxt;
    fin_id_r    <= fin_id_nxt;
    fin_found_r <= fin_found_nxt;
    cmd_r       <= cmd_nxt;
    if (push) begin
      out_kind_r  <= push_kind;
      out_id_r    <= push_id;
      out_found_r <= push_found;
      out_sleep_r <= push_sleep;
      out_last_r  <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wa_en) begin
      slot_id_r[wa_idx]  <= wa_id;
      slot_due_r[wa_idx] <= wa_due;
      slot_per_r[wa_idx] <= wa_per;
    end
    if (wb_en) begin
      slot_id_r[wb_idx]  <= wb_id;
      slot_due_r[wb_idx] <= wb_due;
      slot_per_r[wb_idx] <= wb_per;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_val_r <= '0;
    end else begin
      if (wa_en) begin
        slot_val_r[wa_idx] <= wa_val;
      end
      if (wb_en) begin
        slot_val_r[wb_idx] <= wb_val;
      end
      if (clr_tail) begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (CW'(k) >= kept_r && CW'(k) < live_r) begin
            slot_val_r[k] <= 1'b0;
          end
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_sleep_r, out_found_r, out_id_r};

endmodule

>>> hdl/timed_task_scheduler_table.sv
// Top level of the timed task scheduler table.
// Instantiates tts_front and tts_engine; depends on tts_pkg.
//
// Each input transaction is queued by a two-entry front queue and carried out
// by a sequential engine. A schedule into a full table is answered without a
// search or sort; any other schedule goes straight to a selection sort of the n
// live slots, while the other operations first run a search or tick scan of up
// to n slots. A tick that fires no task skips the sort. The sort's compare loop
// reads one slot per cycle. Results leave through a registered output stage.
module timed_task_scheduler_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tts_pkg::IN_DATA_W-1:0]   in_tdata,   // target_id, delay_seconds, repeat_req
  input  logic [tts_pkg::OP_W-1:0]        in_tuser,   // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tts_pkg::OUT_DATA_W-1:0]  out_tdata,  // task_id, found, sleep_seconds
  output logic [tts_pkg::KIND_W-1:0]      out_tuser,  // kind
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [tts_pkg::SLEEP_W-1:0]     cfg_wr_data
);
  import tts_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  tts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  tts_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

>>> hdl/tts_checker.sv
// Port-level checks for the timed task scheduler table, bound to the top level.
// Depends on tts_pkg.
module tts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tts_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [tts_pkg::KIND_W-1:0]      out_tuser,
  input logic                            out_tlast
);
  import tts_pkg::*;

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_due_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DUE |-> !out_tlast)
    else $error("due task marked as last");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DUE |-> out_tlast)
    else $error("final result not marked as last");

  a_sleep_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_TICK_DONE |-> out_tdata[32:17] == '0)
    else $error("sleep time on a non-tick result");

endmodule

bind timed_task_scheduler_table tts_checker u_tts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
